/* hdl/slcfr_pkg.sv */
// ----------------------------------------------------------------------------
// slcfr_pkg
// Shared types, codes and constants of the sync/length/CRC16 frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package slcfr_pkg;

    localparam logic [7:0]  SYNC_FIRST   = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND  = 8'h55;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_TOP      = 16'h8000;
    localparam logic [15:0] PKT_LEN_RST  = 16'd64;
    localparam logic [15:0] PAUSE_LEN    = 16'd1;

    // Depth of the queue between the classifier and the frame engine.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        ST_PACKET_OK = 3'd0,
        ST_PAUSE_OK  = 3'd1,
        ST_CRC_BAD   = 3'd2,
        ST_TIMEOUT   = 3'd3,
        ST_UNKNOWN   = 3'd4
    } t_status;

    typedef enum logic [7:0] {
        PH_HUNT1   = 8'b0000_0001,
        PH_HUNT2   = 8'b0000_0010,
        PH_LEN_LO  = 8'b0000_0100,
        PH_LEN_HI  = 8'b0000_1000,
        PH_PAYLOAD = 8'b0001_0000,
        PH_CRC_LO  = 8'b0010_0000,
        PH_CRC_HI  = 8'b0100_0000,
        PH_DISCARD = 8'b1000_0000
    } t_phase;

    // One classified input event.
    typedef struct packed {
        logic       is_timeout;
        logic       is_sync1;
        logic       is_sync2;
        logic [7:0] data;
    } t_cmd;

    // MSB-first CRC16 update over one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/slcfr_if.sv */
// ----------------------------------------------------------------------------
// slcfr interfaces
// Valid/ready channels for input events, frame results and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface slcfr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;
    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface slcfr_out_if;
    logic       valid;
    logic       ready;
    logic       is_frame_end;
    logic [7:0] out_byte;
    logic [2:0] frame_status;
    modport source (output valid, output is_frame_end, output out_byte,
                    output frame_status, input ready);
    modport sink   (input valid, input is_frame_end, input out_byte,
                    input frame_status, output ready);
endinterface

interface slcfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/slcfr_front.sv */
// ----------------------------------------------------------------------------
// slcfr_front
// Accepts input events and tags them as timeout or sync byte for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module slcfr_front (
    slcfr_in_if.sink        i_in,
    input  wire logic       i_q_full,
    output slcfr_pkg::t_cmd o_cmd,
    output logic            o_push
);

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_cmd.is_timeout = i_in.kind;
        o_cmd.is_sync1   = (i_in.rx_byte == slcfr_pkg::SYNC_FIRST);
        o_cmd.is_sync2   = (i_in.rx_byte == slcfr_pkg::SYNC_SECOND);
        o_cmd.data       = i_in.rx_byte;
    end

endmodule

`default_nettype wire

/* hdl/slcfr_queue.sv */
// ----------------------------------------------------------------------------
// slcfr_queue
// Short FIFO of classified events between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module slcfr_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire slcfr_pkg::t_cmd i_cmd,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output slcfr_pkg::t_cmd      o_cmd
);

    localparam logic [slcfr_pkg::QPTR_W-1:0] PTR_LAST =
        slcfr_pkg::QPTR_W'(slcfr_pkg::QDEPTH - 1);
    localparam logic [slcfr_pkg::QCNT_W-1:0] CNT_FULL =
        slcfr_pkg::QCNT_W'(slcfr_pkg::QDEPTH);

    slcfr_pkg::t_cmd                r_mem [slcfr_pkg::QDEPTH];
    logic [slcfr_pkg::QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [slcfr_pkg::QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [slcfr_pkg::QCNT_W-1:0]   r_count, n_count;
    logic                           do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* hdl/slcfr_back.sv */
// ----------------------------------------------------------------------------
// slcfr_back
// Frame engine: sync hunt, length decode, CRC check and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module slcfr_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    slcfr_cfg_if.sink            i_cfg,
    input  wire logic            i_q_valid,
    input  wire slcfr_pkg::t_cmd i_cmd,
    output logic                 o_pop,
    slcfr_out_if.source          o_out
);

    slcfr_pkg::t_phase  r_phase, n_phase;
    logic [15:0]        r_pkt_len;
    logic [7:0]         r_len_lo, n_len_lo;
    logic [16:0]        r_bytes_left, n_bytes_left;
    logic [15:0]        r_crc, n_crc;
    logic [7:0]         r_trl_lo, n_trl_lo;
    logic               r_pause, n_pause;
    logic [7:0]         r_pause_val, n_pause_val;

    logic               r_out_valid, n_out_valid;
    logic               r_out_end;
    logic [7:0]         r_out_byte;
    slcfr_pkg::t_status r_out_status;

    logic               res_valid;
    logic               res_end;
    logic [7:0]         res_byte;
    slcfr_pkg::t_status res_status;

    logic [15:0]        len;
    logic [16:0]        left_dec;

    assign i_cfg.ready = 1'b1;

    // The next event is taken whenever the result register is free this cycle.
    assign o_pop    = i_q_valid && (!r_out_valid || o_out.ready);
    assign len      = {i_cmd.data, r_len_lo};
    assign left_dec = r_bytes_left - 17'd1;

    always_comb begin
        n_phase      = r_phase;
        n_len_lo     = r_len_lo;
        n_bytes_left = r_bytes_left;
        n_crc        = r_crc;
        n_trl_lo     = r_trl_lo;
        n_pause      = r_pause;
        n_pause_val  = r_pause_val;
        res_valid    = 1'b0;
        res_end      = 1'b1;
        res_byte     = 8'h00;
        res_status   = slcfr_pkg::ST_PACKET_OK;
        if (o_pop) begin
            if (i_cmd.is_timeout) begin
                n_phase = slcfr_pkg::PH_HUNT1;
                if (r_phase != slcfr_pkg::PH_HUNT1 && r_phase != slcfr_pkg::PH_HUNT2) begin
                    res_valid  = 1'b1;
                    res_status = slcfr_pkg::ST_TIMEOUT;
                end
            end else begin
                unique case (r_phase)
                    slcfr_pkg::PH_HUNT1: begin
                        if (i_cmd.is_sync1) begin
                            n_phase = slcfr_pkg::PH_HUNT2;
                        end
                    end
                    slcfr_pkg::PH_HUNT2: begin
                        n_phase = i_cmd.is_sync2 ? slcfr_pkg::PH_LEN_LO
                                                 : slcfr_pkg::PH_HUNT1;
                    end
                    slcfr_pkg::PH_LEN_LO: begin
                        n_len_lo = i_cmd.data;
                        n_phase  = slcfr_pkg::PH_LEN_HI;
                    end
                    slcfr_pkg::PH_LEN_HI: begin
                        n_crc = slcfr_pkg::CRC_INIT;
                        if (len == r_pkt_len || len == slcfr_pkg::PAUSE_LEN) begin
                            n_pause      = (len != r_pkt_len);
                            n_bytes_left = {1'b0, len};
                            n_phase      = (len == 16'd0) ? slcfr_pkg::PH_CRC_LO
                                                          : slcfr_pkg::PH_PAYLOAD;
                        end else begin
                            n_pause      = 1'b0;
                            n_bytes_left = {1'b0, len} + 17'd2;
                            n_phase      = slcfr_pkg::PH_DISCARD;
                        end
                    end
                    slcfr_pkg::PH_PAYLOAD: begin
                        n_crc        = slcfr_pkg::crc_byte(r_crc, i_cmd.data);
                        n_bytes_left = left_dec;
                        if (left_dec == 17'd0) begin
                            n_phase = slcfr_pkg::PH_CRC_LO;
                        end
                        if (r_pause) begin
                            n_pause_val = i_cmd.data;
                        end else begin
                            res_valid = 1'b1;
                            res_end   = 1'b0;
                            res_byte  = i_cmd.data;
                        end
                    end
                    slcfr_pkg::PH_CRC_LO: begin
                        n_trl_lo = i_cmd.data;
                        n_phase  = slcfr_pkg::PH_CRC_HI;
                    end
                    slcfr_pkg::PH_CRC_HI: begin
                        n_phase   = slcfr_pkg::PH_HUNT1;
                        res_valid = 1'b1;
                        if ({i_cmd.data, r_trl_lo} != r_crc) begin
                            res_status = slcfr_pkg::ST_CRC_BAD;
                        end else if (r_pause) begin
                            res_status = slcfr_pkg::ST_PAUSE_OK;
                            res_byte   = r_pause_val;
                        end
                    end
                    slcfr_pkg::PH_DISCARD: begin
                        n_bytes_left = left_dec;
                        if (left_dec == 17'd0) begin
                            n_phase    = slcfr_pkg::PH_HUNT1;
                            res_valid  = 1'b1;
                            res_status = slcfr_pkg::ST_UNKNOWN;
                        end
                    end
                    default: begin
                        n_phase = slcfr_pkg::PH_HUNT1;
                    end
                endcase
            end
        end
        // A pending result stays until its transfer; a pop implies the slot is free.
        n_out_valid = (o_pop && res_valid) || (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= slcfr_pkg::PH_HUNT1;
            r_pkt_len    <= slcfr_pkg::PKT_LEN_RST;
            r_len_lo     <= 8'h00;
            r_bytes_left <= '0;
            r_crc        <= slcfr_pkg::CRC_INIT;
            r_trl_lo     <= 8'h00;
            r_pause      <= 1'b0;
            r_pause_val  <= 8'h00;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_len_lo     <= n_len_lo;
            r_bytes_left <= n_bytes_left;
            r_crc        <= n_crc;
            r_trl_lo     <= n_trl_lo;
            r_pause      <= n_pause;
            r_pause_val  <= n_pause_val;
            r_out_valid  <= n_out_valid;
            if (i_cfg.valid) begin
                r_pkt_len <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && res_valid) begin
            r_out_end    <= res_end;
            r_out_byte   <= res_byte;
            r_out_status <= res_status;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.is_frame_end = r_out_end;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.frame_status = r_out_status;

    a_no_pop_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !(r_out_valid && !o_out.ready))
        else $error("event taken while a result is blocked");

    a_payload_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_end) |-> (r_out_status == slcfr_pkg::ST_PACKET_OK))
        else $error("payload result with nonzero status");

    a_payload_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == slcfr_pkg::PH_PAYLOAD) |-> (r_bytes_left != 17'd0))
        else $error("payload phase with no bytes left");

    a_discard_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_cmd.is_timeout && r_phase == slcfr_pkg::PH_DISCARD
         && r_bytes_left == 17'd1)
        |=> (r_out_valid && r_out_status == slcfr_pkg::ST_UNKNOWN))
        else $error("discard end did not report unknown length");

endmodule

`default_nettype wire

/* hdl/sync_length_crc16_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_receiver
// Hunts for 0xAA 0x55, reads a little-endian length, passes data payload
// bytes out and reports the frame end after a CRC16-CCITT trailer check.
// ----------------------------------------------------------------------------
//   Channel   Dir   Payload                                  Transfer
//   i_in      in    kind, rx_byte                            valid && ready
//   o_out     out   is_frame_end, out_byte, frame_status     valid && ready
//   i_cfg     in    data = packet_length (16 bit)            valid && ready
//
// One event per cycle sustained while results are taken; a result's valid rises
// once its input has passed the event queue register and the registered result
// slot. The frame engine steps one byte per cycle while not stalled, including
// the full byte-wide CRC.
// Synchronous active-low reset returns to sync hunting with packet_length 64.
// A stalled result holds the engine; the queue then fills and lowers i_in.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_crc16_frame_receiver (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    slcfr_in_if.sink    i_in,
    slcfr_cfg_if.sink   i_cfg,
    slcfr_out_if.source o_out
);

    slcfr_pkg::t_cmd front_cmd;
    slcfr_pkg::t_cmd q_cmd;
    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            pop;

    slcfr_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_cmd    (front_cmd),
        .o_push   (push)
    );

    slcfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    slcfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
